// File: rtl/mopf_pkg.sv
// Shared types and constants for the multimode one-pole filter cascade.
// Holds register indexes, mode codes, datapath op codes and the
// command/status structs. No dependencies.
package mopf_pkg;

  // Default sizing, handed down to the top level
  localparam int MAX_STAGES_DEF  = 8;
  localparam int SAMPLE_BITS_DEF = 24;

  // Internal arithmetic widths
  localparam int STATE_W = 32;  // stage state, saturating
  localparam int DIFF_W  = 34;  // multiplier difference operand
  localparam int COEF_W  = 16;  // Q0.16 coefficients
  localparam int PROD_W  = 51;  // (COEF_W+1) x DIFF_W product
  localparam int ACC_W   = 36;  // state plus two rounded terms

  // Filter modes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_BYPASS = 2'd0;
  localparam mode_t MODE_LOW    = 2'd1;
  localparam mode_t MODE_HIGH   = 2'd2;
  localparam mode_t MODE_BAND   = 2'd3;

  // Register indexes on the configuration port
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_MODE   = 2'd0;
  localparam reg_idx_t REG_COUNT  = 2'd1;
  localparam reg_idx_t REG_CUTOFF = 2'd2;
  localparam reg_idx_t REG_RES    = 2'd3;

  // Register reset values
  localparam mode_t             MODE_RST   = MODE_LOW;
  localparam logic [3:0]        COUNT_RST  = 4'd1;
  localparam logic [COEF_W-1:0] CUTOFF_RST = 16'd9266;
  localparam logic [COEF_W-1:0] RES_RST    = 16'd0;

  // Datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE     = 4'd0;
  localparam op_t OP_LOAD     = 4'd1;   // take the input sample
  localparam op_t OP_READ     = 4'd2;   // read stage state
  localparam op_t OP_SET_LOW  = 4'd3;   // smooth the low state toward src
  localparam op_t OP_SET_BAND = 4'd4;   // smooth the band state toward src - low
  localparam op_t OP_MUL_Q1   = 4'd5;   // q1 * (target - state)
  localparam op_t OP_MUL_Q2   = 4'd6;   // add, then q2 * (state - history)
  localparam op_t OP_ADD      = 4'd7;   // add last rounded product
  localparam op_t OP_WR_LOW   = 4'd8;   // store low state, advance unless band
  localparam op_t OP_WR_BAND  = 4'd9;   // store band state, advance signal
  localparam op_t OP_OUT      = 4'd10;  // load the output register

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// File: rtl/mopf_in_if.sv
// Input sample channel: valid/ready handshake with one signed sample.
// Depends on mopf_pkg for the default sample width.
interface mopf_in_if #(
  parameter int SAMPLE_BITS = mopf_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// File: rtl/mopf_out_if.sv
// Output sample channel: valid/ready handshake with one signed sample.
// Depends on mopf_pkg for the default sample width.
interface mopf_out_if #(
  parameter int SAMPLE_BITS = mopf_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// File: rtl/multimode_one_pole_filter_cascade.sv
// Top level of the multimode one-pole filter cascade: configuration
// registers, sequencer and datapath. Depends on mopf_pkg, mopf_in_if,
// mopf_out_if, mopf_ctrl and mopf_dp.
//
// Usage: samples (signed Q1.23 at the default width) enter on sample_ch and
// filtered samples leave on result_ch, one result per item, in order. The
// APB port sets mode, stage_count, cutoff_coeff and resonance_coeff; write it
// only while no item is in flight. A change of the effective stage count
// clears all stage state; a mode change keeps it.
// Schedule: one shared multiplier walks the stages one after another;
// band-pass runs a low then a band update per stage, resonance adds a
// multiply (in band-pass to the band update only), bypass skips the
// stages. The next item is accepted the cycle after the result is loaded.
// Reset: registers return to low-pass, one stage, cutoff 9266, no
// resonance, and all stage state reads as zero.
// Stall: the output register holds a result until taken; a finished item
// waits for that register, while input stays closed during processing.
module multimode_one_pole_filter_cascade #(
  parameter int MAX_STAGES  = mopf_pkg::MAX_STAGES_DEF,
  parameter int SAMPLE_BITS = mopf_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mopf_in_if.sink     sample_ch,
  mopf_out_if.source  result_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mopf_pkg::*;

  localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

  mode_t             mode;
  logic [3:0]        stage_count;
  logic [COEF_W-1:0] cutoff_coeff;
  logic [COEF_W-1:0] resonance_coeff;

  reg_idx_t          idx;
  logic              wr;
  logic [3:0]        count_clamped;
  logic              clr;

  cmd_t              cmd;
  sts_t              sts;
  logic [SW-1:0]     stage;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite && pready;

  // Clamp the requested stage count into 1..MAX_STAGES
  always_comb begin
    if (pwdata[3:0] == 4'd0) begin
      count_clamped = 4'd1;
    end else if (32'(pwdata[3:0]) > MAX_STAGES) begin
      count_clamped = 4'(MAX_STAGES);
    end else begin
      count_clamped = pwdata[3:0];
    end
  end

  // Drop stage state when the effective order changes
  assign clr = wr && (idx == REG_COUNT) && (count_clamped != stage_count);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_RST;
      stage_count     <= COUNT_RST;
      cutoff_coeff    <= CUTOFF_RST;
      resonance_coeff <= RES_RST;
    end else if (wr) begin
      unique case (idx)
        REG_MODE:   mode            <= pwdata[1:0];
        REG_COUNT:  stage_count     <= count_clamped;
        REG_CUTOFF: cutoff_coeff    <= pwdata[COEF_W-1:0];
        REG_RES:    resonance_coeff <= pwdata[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = 32'(mode);
      REG_COUNT:  prdata = 32'(stage_count);
      REG_CUTOFF: prdata = 32'(cutoff_coeff);
      REG_RES:    prdata = 32'(resonance_coeff);
      default:    prdata = '0;
    endcase
  end

  mopf_ctrl #(
    .MAX_STAGES (MAX_STAGES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (sample_ch.valid),
    .in_ready    (sample_ch.ready),
    .mode        (mode),
    .stage_count (stage_count),
    .res_on      (resonance_coeff != '0),
    .sts         (sts),
    .cmd         (cmd),
    .stage       (stage)
  );

  mopf_dp #(
    .MAX_STAGES  (MAX_STAGES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stage      (stage),
    .mode       (mode),
    .q1         (cutoff_coeff),
    .q2         (resonance_coeff),
    .clr        (clr),
    .sample_in  (sample_ch.sample_in),
    .sample_out (result_ch.sample_out),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .sts        (sts)
  );

endmodule

// File: rtl/mopf_ctrl.sv
// Sequencer for the filter cascade: walks the stages one by one, issuing
// one datapath op per cycle unless idle or stalled. Depends on mopf_pkg.
module mopf_ctrl #(
  parameter int MAX_STAGES = mopf_pkg::MAX_STAGES_DEF,
  localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        mode,
  input  logic [3:0]        stage_count,
  input  logic              res_on,
  input  mopf_pkg::sts_t    sts,
  output mopf_pkg::cmd_t    cmd,
  output logic [SW-1:0]     stage
);
  import mopf_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_SET    = 3'd2;
  localparam logic [2:0] ST_MUL1   = 3'd3;
  localparam logic [2:0] ST_MUL2   = 3'd4;
  localparam logic [2:0] ST_ADD    = 3'd5;
  localparam logic [2:0] ST_WR     = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  logic [2:0]    state, state_next;
  logic [SW-1:0] stage_next;
  logic          phase, phase_next;   // band-pass: 0 low update, 1 band update
  logic          band_low;            // low update inside a band-pass stage
  logic          last_stage;

  assign band_low   = (mode == MODE_BAND) && !phase;
  assign last_stage = (32'(stage) + 32'd1) == 32'(stage_count);
  assign in_ready   = (state == ST_IDLE);

  // Next state and datapath command
  always_comb begin
    state_next = state;
    stage_next = stage;
    phase_next = phase;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          stage_next = '0;
          phase_next = 1'b0;
          state_next = (mode == MODE_BYPASS) ? ST_FINISH : ST_READ;
        end
      end
      ST_READ: begin
        cmd.op     = OP_READ;
        state_next = ST_SET;
      end
      ST_SET: begin
        cmd.op     = phase ? OP_SET_BAND : OP_SET_LOW;
        state_next = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.op     = OP_MUL_Q1;
        state_next = (res_on && !band_low) ? ST_MUL2 : ST_ADD;
      end
      ST_MUL2: begin
        cmd.op     = OP_MUL_Q2;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.op     = OP_ADD;
        state_next = ST_WR;
      end
      ST_WR: begin
        cmd.op = phase ? OP_WR_BAND : OP_WR_LOW;
        if (band_low) begin
          phase_next = 1'b1;
          state_next = ST_SET;
        end else if (last_stage) begin
          state_next = ST_FINISH;
        end else begin
          stage_next = SW'(stage + 1'b1);
          phase_next = 1'b0;
          state_next = ST_READ;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.op     = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold state and stage position
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      stage <= '0;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      stage <= stage_next;
      phase <= phase_next;
    end
  end

endmodule

// File: rtl/mopf_dp.sv
// Datapath of the filter cascade: stage state stores, one shared
// coefficient multiplier, accumulator and output register. Depends on mopf_pkg.
module mopf_dp #(
  parameter int MAX_STAGES  = mopf_pkg::MAX_STAGES_DEF,
  parameter int SAMPLE_BITS = mopf_pkg::SAMPLE_BITS_DEF,
  localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mopf_pkg::cmd_t                cmd,
  input  logic [SW-1:0]                 stage,
  input  logic [1:0]                    mode,
  input  logic [15:0]                   q1,
  input  logic [15:0]                   q2,
  input  logic                          clr,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mopf_pkg::sts_t                sts
);
  import mopf_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_HI = 36'sh0_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_LO = 36'shF_8000_0000;
  localparam logic signed [STATE_W-1:0] SMP_HI =
    STATE_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [STATE_W-1:0] SMP_LO = -SMP_HI - 32'sd1;

  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > ACC_HI) begin
      return ACC_HI[STATE_W-1:0];
    end else if (v < ACC_LO) begin
      return ACC_LO[STATE_W-1:0];
    end
    return STATE_W'(v);
  endfunction

  // Stage state stores; prior-output history for resonance
  logic signed [STATE_W-1:0] low_mem  [MAX_STAGES];
  logic signed [STATE_W-1:0] band_mem [MAX_STAGES];
  logic signed [STATE_W-1:0] prev_mem [MAX_STAGES];
  logic [MAX_STAGES-1:0]     low_vld, band_vld, prev_vld;

  logic signed [STATE_W-1:0] rd_low, rd_band, rd_prev;
  logic signed [STATE_W-1:0] cur;     // state being smoothed
  logic signed [DIFF_W-1:0]  tgt;     // its target
  logic signed [STATE_W-1:0] src;     // running signal through the cascade
  logic signed [STATE_W-1:0] tlow;    // fresh low state in band-pass
  logic signed [ACC_W-1:0]   acc;
  logic signed [PROD_W-1:0]  prod;

  logic signed [COEF_W:0]    mul_coef;
  logic signed [DIFF_W-1:0]  mul_diff;
  logic signed [PROD_W-1:0]  prod_rnd;
  logic signed [ACC_W-1:0]   rnd_term;
  logic signed [ACC_W-1:0]   acc_sum;
  logic signed [STATE_W-1:0] acc_sat;
  logic signed [STATE_W-1:0] hp_next;
  logic signed [STATE_W-1:0] out_clip;

  // Select multiplier operands
  always_comb begin
    if (cmd.op == OP_MUL_Q2) begin
      mul_coef = {1'b0, q2};
      mul_diff = DIFF_W'(cur) - DIFF_W'(rd_prev);
    end else begin
      mul_coef = {1'b0, q1};
      mul_diff = tgt - DIFF_W'(cur);
    end
  end

  // Round product to sample scale (halves up), accumulate, saturate
  assign prod_rnd = prod + PROD_W'(32768);
  assign rnd_term = ACC_W'(prod_rnd >>> 16);
  assign acc_sum  = acc + rnd_term;
  assign acc_sat  = sat32(acc);
  assign hp_next  = sat32(ACC_W'(src) - ACC_W'(acc_sat));

  // Clip the running signal to the sample range
  always_comb begin
    if (src > SMP_HI) begin
      out_clip = SMP_HI;
    end else if (src < SMP_LO) begin
      out_clip = SMP_LO;
    end else begin
      out_clip = src;
    end
  end

  // Execute the command
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        src <= STATE_W'(sample_in);
      end
      OP_READ: begin
        rd_low  <= low_vld[stage]  ? low_mem[stage]  : '0;
        rd_band <= band_vld[stage] ? band_mem[stage] : '0;
        rd_prev <= prev_vld[stage] ? prev_mem[stage] : '0;
      end
      OP_SET_LOW: begin
        cur <= rd_low;
        tgt <= DIFF_W'(src);
        acc <= ACC_W'(rd_low);
      end
      OP_SET_BAND: begin
        cur <= rd_band;
        tgt <= DIFF_W'(src) - DIFF_W'(tlow);
        acc <= ACC_W'(rd_band);
      end
      OP_MUL_Q1: begin
        prod <= PROD_W'(mul_coef) * PROD_W'(mul_diff);
      end
      OP_MUL_Q2: begin
        acc             <= acc_sum;
        prod            <= PROD_W'(mul_coef) * PROD_W'(mul_diff);
        prev_mem[stage] <= cur;
      end
      OP_ADD: begin
        acc <= acc_sum;
      end
      OP_WR_LOW: begin
        low_mem[stage] <= acc_sat;
        tlow           <= acc_sat;
        if (mode == MODE_LOW) begin
          src <= acc_sat;
        end else if (mode == MODE_HIGH) begin
          src <= hp_next;
        end
      end
      OP_WR_BAND: begin
        band_mem[stage] <= acc_sat;
        src             <= acc_sat;
      end
      OP_OUT: begin
        sample_out <= SAMPLE_BITS'(out_clip);
      end
      default: begin
      end
    endcase
  end

  // Valid bits: cleared at reset and on an order change
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      low_vld  <= '0;
      band_vld <= '0;
      prev_vld <= '0;
    end else begin
      if (cmd.op == OP_WR_LOW) begin
        low_vld[stage] <= 1'b1;
      end
      if (cmd.op == OP_WR_BAND) begin
        band_vld[stage] <= 1'b1;
      end
      if (cmd.op == OP_MUL_Q2) begin
        prev_vld[stage] <= 1'b1;
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule

// File: sim/tb_multimode_one_pole_filter_cascade.sv
// Self-checking bench for the multimode one-pole filter cascade: a directed
// table, then randomized phases of settings and samples, checked by a bit-exact
// predictor. Depends on mopf_pkg, mopf_in_if, mopf_out_if and the DUT.
`timescale 1ns / 100ps

module tb_multimode_one_pole_filter_cascade;
  import mopf_pkg::*;

  localparam int     NUM_ST      = MAX_STAGES_DEF;
  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     TAIL_CYCLES = 100;   // outlasts the slowest item
  localparam int     PHASES      = 15;
  localparam int     PHASE_ITEMS = 40;
  localparam longint SAT_HI      = 64'sd2147483647;
  localparam longint SAT_LO      = -64'sd2147483648;
  localparam logic signed [23:0] SMP_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SMP_MIN = 24'sh800000;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    reg_idx_t           idx;
    logic [31:0]        wval;
    logic signed [23:0] smp;
    logic               known;
    logic signed [23:0] want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mopf_in_if  in_ch ();
  mopf_out_if out_ch ();

  multimode_one_pole_filter_cascade DUT (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (in_ch),
    .result_ch (out_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Predictor copy of the settings and stage state
  mode_t cfg_mode;
  int    cfg_count;
  int    cfg_cut;
  int    cfg_res;
  int    low_st  [NUM_ST];
  int    band_st [NUM_ST];
  int    hist1   [NUM_ST];
  int    hist2   [NUM_ST];

  logic signed [23:0] predicted_out [$];
  dir_row_t           dir_rows [$];

  int  cycle_cnt    = 0;
  int  mismatches   = 0;
  int  compared     = 0;
  int  items_sent   = 0;
  int  settings_cnt = 0;
  int  hold_off_req = 0;
  bit  quiet        = 1'b0;

  // Clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_multimode_one_pole_filter_cascade: done, errors");
      $finish;
    end
  end

  function automatic int sat32(longint v);
    if (v > SAT_HI) return int'(SAT_HI);
    if (v < SAT_LO) return int'(SAT_LO);
    return int'(v);
  endfunction

  // Q0.16 product back to sample scale, halves rounded up
  function automatic longint round_q16(longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic void clear_stages();
    int j;
    for (j = 0; j < NUM_ST; j++) begin
      low_st[j]  = 0;
      band_st[j] = 0;
      hist1[j]   = 0;
      hist2[j]   = 0;
    end
  endfunction

  // Move one state toward target; resonance pushes the stage history
  function automatic int smooth_val(int cur, longint target, int k);
    longint acc;
    acc = longint'(cur) + round_q16(longint'(cfg_cut) * (target - longint'(cur)));
    if (cfg_res != 0) begin
      hist2[k] = hist1[k];
      hist1[k] = cur;
      acc += round_q16(longint'(cfg_res) * (longint'(cur) - longint'(hist2[k])));
    end
    return sat32(acc);
  endfunction

  // Track a register write; a new effective order wipes the stages
  function automatic void apply_setting(reg_idx_t idx, logic [31:0] val);
    int n;
    case (idx)
      REG_MODE: cfg_mode = mode_t'(val[1:0]);
      REG_COUNT: begin
        n = int'(val[3:0]);
        if (n < 1) n = 1;
        if (n > NUM_ST) n = NUM_ST;
        if (n != cfg_count) clear_stages();
        cfg_count = n;
      end
      REG_CUTOFF: cfg_cut = int'(val[15:0]);
      REG_RES: cfg_res = int'(val[15:0]);
      default: ;
    endcase
  endfunction

  // Filter one sample through the cascade and saturate to the sample width
  function automatic logic signed [23:0] filter_step(logic signed [23:0] x_in);
    longint x;
    longint y;
    longint src;
    int     t;
    int     tl;
    int     j;
    int     n;
    x = longint'(x_in);
    n = cfg_count;
    case (cfg_mode)
      MODE_LOW: begin
        low_st[0] = smooth_val(low_st[0], x, 0);
        for (j = 1; j < n; j++)
          low_st[j] = smooth_val(low_st[j], longint'(low_st[j-1]), j);
        y = longint'(low_st[n-1]);
      end
      MODE_HIGH: begin
        low_st[0] = smooth_val(low_st[0], x, 0);
        t = sat32(x - longint'(low_st[0]));
        for (j = 1; j < n; j++) begin
          low_st[j] = smooth_val(low_st[j], longint'(t), j);
          t = sat32(longint'(t) - longint'(low_st[j]));
        end
        y = longint'(t);
      end
      MODE_BAND: begin
        src = x;
        for (j = 0; j < n; j++) begin
          tl = sat32(longint'(low_st[j]) +
                     round_q16(longint'(cfg_cut) * (src - longint'(low_st[j]))));
          low_st[j]  = tl;
          band_st[j] = smooth_val(band_st[j], src - longint'(tl), j);
          src = longint'(band_st[j]);
        end
        y = longint'(band_st[n-1]);
      end
      default: y = x;
    endcase
    if (y > longint'(SMP_MAX)) y = longint'(SMP_MAX);
    if (y < longint'(SMP_MIN)) y = longint'(SMP_MIN);
    return y[23:0];
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_write(reg_idx_t idx, logic [31:0] val);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.wval  = val;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_sample(logic signed [23:0] s, logic known,
                                     logic signed [23:0] want);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_SAMPLE;
    r.smp   = s;
    r.known = known;
    r.want  = want;
    dir_rows.push_back(r);
  endfunction

  // Random sample: extremes, repeats, small values and full-range noise
  function automatic logic signed [23:0] next_sample(logic signed [23:0] prev);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return SMP_MAX;
    if (r == 1) return SMP_MIN;
    if (r < 4) return prev;
    if (r < 7) return 24'($signed($urandom_range(0, 512)) - 256);
    return 24'($urandom);
  endfunction

  // Register write: setup phase, access phase until pready, then the bus idles
  task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_setting(idx, val);
    @(posedge clk);
  endtask

  // Drop valid and hold until every result is back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (predicted_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Offer one item; on acceptance queue its expected output
  task automatic push_sample(input logic signed [23:0] s, input logic known,
                             input logic signed [23:0] want);
    int                 gap;
    logic signed [23:0] pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= s;
    do @(posedge clk); while (!in_ch.ready);
    pred = filter_step(s);
    predicted_out.push_back(known ? want : pred);
    items_sent++;
  endtask

  // Result side: random stalls, plus the long hold-off when asked
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_req > 0) begin
        stall        = hold_off_req;
        hold_off_req = 0;
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin : result_check
    logic signed [23:0] want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (predicted_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected sample_out %0d", $time, out_ch.sample_out);
      end else begin
        want = predicted_out.pop_front();
        compared++;
        if (out_ch.sample_out !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: sample_out expected %0d, got %0d", $time, want,
                     out_ch.sample_out);
        end
      end
    end
  end

  initial begin : stimulus
    int                 p;
    int                 i;
    int                 k;
    int                 cnt;
    logic [31:0]        v;
    logic signed [23:0] smp;
    dir_row_t           r;

    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.sample_in <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;

    // Reset view of the settings
    cfg_mode  = MODE_RST;
    cfg_count = int'(COUNT_RST);
    cfg_cut   = int'(CUTOFF_RST);
    cfg_res   = int'(RES_RST);
    clear_stages();

    // Low-pass out of reset: silence stays silent, then the extremes
    add_sample(24'sd0, 1'b1, 24'sd0);
    add_sample(SMP_MAX, 1'b0, '0);
    add_sample(SMP_MIN, 1'b0, '0);
    // Bypass passes the sample through untouched
    add_write(REG_MODE, 32'(MODE_BYPASS));
    add_sample(SMP_MIN, 1'b1, SMP_MIN);
    add_sample(SMP_MAX, 1'b1, SMP_MAX);
    add_sample(24'sh555555, 1'b1, 24'sh555555);
    add_sample(24'shAAAAAA, 1'b1, 24'shAAAAAA);
    // High-pass on cleared stages with a frozen low state returns the input
    add_write(REG_COUNT, 32'd2);
    add_write(REG_CUTOFF, 32'd0);
    add_write(REG_MODE, 32'(MODE_HIGH));
    add_sample(SMP_MAX, 1'b1, SMP_MAX);
    add_sample(SMP_MIN, 1'b1, SMP_MIN);
    // Full cascade, fastest cutoff, strongest resonance
    add_write(REG_COUNT, 32'd8);
    add_write(REG_CUTOFF, 32'hFFFF);
    add_write(REG_RES, 32'hFFFF);
    add_sample(SMP_MAX, 1'b0, '0);
    add_sample(SMP_MIN, 1'b0, '0);
    add_sample(SMP_MAX, 1'b0, '0);
    // Band-pass keeps the state left by high-pass
    add_write(REG_MODE, 32'(MODE_BAND));
    add_sample(SMP_MIN, 1'b0, '0);
    add_sample(SMP_MAX, 1'b0, '0);
    add_sample(24'sd1, 1'b0, '0);
    // Count of zero counts as one, resonance off
    add_write(REG_MODE, 32'(MODE_LOW));
    add_write(REG_COUNT, 32'd0);
    add_write(REG_RES, 32'd0);
    add_sample(SMP_MAX, 1'b0, '0);
    add_sample(SMP_MIN, 1'b0, '0);
    // Counts above the maximum clamp; a repeat of the same order keeps state
    add_write(REG_COUNT, 32'd15);
    add_sample(SMP_MAX, 1'b0, '0);
    add_sample(24'sd4096, 1'b0, '0);
    add_write(REG_COUNT, 32'd9);
    add_sample(SMP_MIN, 1'b0, '0);
    add_write(REG_MODE, 32'(MODE_BYPASS));
    add_sample(24'sd12345, 1'b1, 24'sd12345);
    add_write(REG_MODE, 32'(MODE_LOW));
    add_sample(-24'sd777, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_WRITE) begin
        wait_drained();
        apb_write(r.idx, r.wval);
        settings_cnt++;
      end else begin
        push_sample(r.smp, r.known, r.want);
      end
    end

    // Random phases: new settings on an idle block, then a run of samples
    smp = '0;
    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      quiet = (p % 4 == 3);
      k = $urandom_range(0, 9);
      v = $urandom;
      v[1:0] = (k == 0) ? MODE_BYPASS : (k < 4) ? MODE_LOW : (k < 7) ? MODE_HIGH : MODE_BAND;
      apply_setting(REG_MODE, v);
      apb_write(REG_MODE, v);
      cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      v = $urandom;
      v[3:0] = 4'(cnt);
      apb_write(REG_COUNT, v);
      k = $urandom_range(0, 5);
      v = $urandom;
      if (k == 0) v[15:0] = 16'h0000;
      else if (k == 1) v[15:0] = 16'hFFFF;
      apb_write(REG_CUTOFF, v);
      k = $urandom_range(0, 7);
      v = $urandom;
      if (k < 4) v[15:0] = 16'h0000;
      else if (k == 4) v[15:0] = 16'hFFFF;
      apb_write(REG_RES, v);
      settings_cnt++;
      // Long receiver hold-off so the block fills and stalls its input
      if (p == 5) hold_off_req = 500;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        smp = next_sample(smp);
        push_sample(smp, 1'b0, '0);
      end
    end

    // Drain and settle
    in_ch.valid <= 1'b0;
    while (predicted_out.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += predicted_out.size();

    $display("Ran %0d samples through %0d settings (all modes, 1..8 stages, resonance",
             items_sent, settings_cnt);
    $display("on and off, coefficient extremes); %0d results compared, %0d mismatches.",
             compared, mismatches);
    if (mismatches == 0) begin
      $display("tb_multimode_one_pole_filter_cascade: done, clean");
    end else begin
      $display("tb_multimode_one_pole_filter_cascade: done, errors");
    end
    $finish;
  end

endmodule
